/* design/sfe_pkg.sv */
// sfe_pkg: shared types, slip byte codes and the escape helper
// used by the slip frame encoder modules; depends on nothing
package sfe_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned MaxRun = 6;
    localparam int unsigned RunW   = $clog2(MaxRun + 1);

    localparam logic [ByteW-1:0] SlipEnd    = 8'hC0;
    localparam logic [ByteW-1:0] SlipEsc    = 8'hDB;
    localparam logic [ByteW-1:0] SlipEscEnd = 8'hDC;
    localparam logic [ByteW-1:0] SlipEscEsc = 8'hDD;

    // line bytes caused by one word, first byte in slot 0
    typedef struct packed {
        logic [MaxRun-1:0][ByteW-1:0] bytes;
        logic [RunW-1:0]              len;
    } t_run;

    typedef struct packed {
        logic [ByteW-1:0] first;
        logic [ByteW-1:0] second;
        logic             two;
    } t_esc;

    function automatic t_esc escape(input logic [ByteW-1:0] b);
        t_esc e;
        e.first  = b;
        e.second = '0;
        e.two    = 1'b0;
        if (b == SlipEnd) begin
            e.first  = SlipEsc;
            e.second = SlipEscEnd;
            e.two    = 1'b1;
        end else if (b == SlipEsc) begin
            e.first  = SlipEsc;
            e.second = SlipEscEsc;
            e.two    = 1'b1;
        end
        return e;
    endfunction

endpackage

/* design/sfe_if.sv */
// sfe_if: valid/ready channel interfaces for packet words and line words
// depends on nothing
interface sfe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface sfe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] line_byte;
    logic       last_of_run;

    modport source (output valid, output line_byte, output last_of_run, input ready);
    modport sink (input valid, input line_byte, input last_of_run, output ready);
endinterface

/* design/sfe_expand.sv */
// sfe_expand: builds the run of line bytes for one packet word
// depends on sfe_pkg
module sfe_expand (
    input  logic [sfe_pkg::ByteW-1:0] i_data_byte,
    input  logic                      i_last_byte,
    input  logic                      i_frame_open,
    input  logic [sfe_pkg::ByteW-1:0] i_running_xor,
    input  logic                      i_use_checksum,
    output sfe_pkg::t_run             o_run
);

    logic [sfe_pkg::ByteW-1:0] csum;
    sfe_pkg::t_esc             esc_d;
    sfe_pkg::t_esc             esc_c;
    logic [sfe_pkg::RunW-1:0]  pos;

    assign csum  = (i_frame_open ? i_running_xor : '0) ^ i_data_byte;
    assign esc_d = sfe_pkg::escape(i_data_byte);
    assign esc_c = sfe_pkg::escape(csum);

    always_comb begin
        o_run = '0;
        pos   = '0;
        if (!i_frame_open) begin
            o_run.bytes[pos] = sfe_pkg::SlipEnd;
            pos              = pos + 1'b1;
        end
        o_run.bytes[pos] = esc_d.first;
        pos              = pos + 1'b1;
        if (esc_d.two) begin
            o_run.bytes[pos] = esc_d.second;
            pos              = pos + 1'b1;
        end
        if (i_last_byte) begin
            if (i_use_checksum) begin
                o_run.bytes[pos] = esc_c.first;
                pos              = pos + 1'b1;
                if (esc_c.two) begin
                    o_run.bytes[pos] = esc_c.second;
                    pos              = pos + 1'b1;
                end
            end
            o_run.bytes[pos] = sfe_pkg::SlipEnd;
            pos              = pos + 1'b1;
        end
        o_run.len = pos;
    end

endmodule

/* design/sfe_emit.sv */
// sfe_emit: run register that shifts line bytes out one per word
// depends on sfe_pkg and sfe_if
module sfe_emit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  sfe_pkg::t_run     i_run,
    output logic              o_can_load,
    sfe_out_if.source         o_out
);

    logic [sfe_pkg::MaxRun-1:0][sfe_pkg::ByteW-1:0] r_bytes;
    logic [sfe_pkg::RunW-1:0]                       r_cnt;
    logic                                           fire;

    assign fire              = o_out.valid && o_out.ready;
    assign o_out.valid       = (r_cnt != '0);
    assign o_out.line_byte   = r_bytes[0];
    assign o_out.last_of_run = (r_cnt == sfe_pkg::RunW'(1));
    // free now, or the final byte of the run leaves this cycle
    assign o_can_load        = (r_cnt == '0) || (o_out.last_of_run && o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_run.len;
        end else if (fire) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bytes <= i_run.bytes;
        end else if (fire) begin
            r_bytes <= r_bytes >> sfe_pkg::ByteW;
        end
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= sfe_pkg::RunW'(sfe_pkg::MaxRun))
        else $error("run count beyond maximum run length");
    a_load_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (i_run.len != '0) && (i_run.len <= sfe_pkg::RunW'(sfe_pkg::MaxRun)))
        else $error("loaded run has no bytes or too many");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (r_cnt == '0) || (r_cnt == sfe_pkg::RunW'(1) && fire))
        else $error("run loaded over bytes still waiting");
    a_count_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && !i_load) |=> r_cnt == $past(r_cnt) - 1'b1)
        else $error("run count did not step down after a word left");
`endif

endmodule

/* design/slip_frame_encoder.sv */
// slip_frame_encoder: top level of the slip (rfc 1055) frame encoder
// depends on sfe_pkg, sfe_if, sfe_expand and sfe_emit
//
// takes packet words (one data byte plus a last-byte flag) and sends slip
// line words: an END before the first byte of each frame, END and ESC in the
// data sent as two-byte escapes, an optional xor checksum of the packet
// (escaped like data) after the last byte when use_checksum is set, and a
// closing END. last_of_run marks the final line word caused by each packet
// word. each packet word makes one to six line words: one for a plain byte
// inside a frame, two for an escaped byte, up to six for an escaped last
// byte with an escaped checksum. the line side moves one word per cycle
// while the receiver is ready, and a packet word holds the run register
// until all its line words have left; a new packet word is taken in the
// same cycle as the final line word of the previous run leaves, so plain
// bytes stream at one per cycle while the receiver is ready. use_checksum is
// sampled when the last byte of a packet arrives; write it only while idle.
module slip_frame_encoder (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata,
    sfe_in_if.sink    i_in,
    sfe_out_if.source o_out
);

    logic                      r_use_checksum;
    logic                      r_frame_open;
    logic [sfe_pkg::ByteW-1:0] r_running_xor;
    logic                      n_frame_open;
    logic [sfe_pkg::ByteW-1:0] n_running_xor;
    logic                      in_fire;
    logic                      can_load;
    sfe_pkg::t_run             run;

    // input word taken whenever the run register frees up this cycle
    assign i_in.ready = can_load;
    assign in_fire    = i_in.valid && can_load;

    // frame state: a last byte closes the frame and clears the checksum
    always_comb begin
        if (i_in.last_byte) begin
            n_frame_open  = 1'b0;
            n_running_xor = '0;
        end else begin
            n_frame_open  = 1'b1;
            n_running_xor = (r_frame_open ? r_running_xor : '0) ^ i_in.data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_checksum <= 1'b0;
            r_frame_open   <= 1'b0;
            r_running_xor  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_use_checksum <= i_cfg_wdata;
            end
            if (in_fire) begin
                r_frame_open  <= n_frame_open;
                r_running_xor <= n_running_xor;
            end
        end
    end

    // escape and framing of one word
    sfe_expand u_expand (
        .i_data_byte    (i_in.data_byte),
        .i_last_byte    (i_in.last_byte),
        .i_frame_open   (r_frame_open),
        .i_running_xor  (r_running_xor),
        .i_use_checksum (r_use_checksum),
        .o_run          (run)
    );

    // run register and line side
    sfe_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (in_fire),
        .i_run      (run),
        .o_can_load (can_load),
        .o_out      (o_out)
    );

`ifndef SYNTHESIS
    a_close_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in.last_byte) |=> !r_frame_open && (r_running_xor == '0))
        else $error("frame state not cleared after last byte");
    a_open_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && !i_in.last_byte) |=> r_frame_open)
        else $error("frame not open after a middle byte");
    a_xor_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_frame_open |-> (r_running_xor == '0))
        else $error("checksum held with no open frame");
`endif

endmodule

/* dv/slip_frame_encoder_tb.sv */
`timescale 1ns / 1ps
// slip_frame_encoder_tb: self-checking bench for the slip frame encoder, with
// random sender bursts and receiver stalls; depends on sfe_pkg, sfe_if and slip_frame_encoder
module slip_frame_encoder_tb;

    localparam int ClkHalf     = 5;
    localparam int ResetCycles = 10;
    localparam int HoldCycles  = 300;   // long receiver hold-off, fills the block
    localparam int QuietLimit  = 2000;  // cycles with no word moving on either side
    localparam int SettleGap   = 8;     // spare cycles before a register write
    localparam int TailCycles  = 16;    // spare cycles after the last line word

    // one packet word as offered to the block
    typedef struct packed {
        logic [sfe_pkg::ByteW-1:0] data;
        logic                      is_last;
    } t_packet_word;

    // one line word as the block should send it
    typedef struct packed {
        logic [sfe_pkg::ByteW-1:0] line_byte;
        logic                      last_of_run;
    } t_line_word;

    // receiver stall behaviour, picked anew for each segment of random length
    typedef enum logic [1:0] {
        ReadyAlways,
        ReadyCoinFlip,
        ReadySparse
    } t_rx_mode;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_cfg_we    = 1'b0;
    logic i_cfg_wdata = 1'b0;

    sfe_in_if  in_ch ();
    sfe_out_if out_ch ();

    slip_frame_encoder uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch.sink),
        .o_out       (out_ch.source)
    );

    always begin
        #ClkHalf i_clk = 1'b1;
        #ClkHalf i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // predictor state: our own copy of the frame state and the option
    // ---------------------------------------------------------------
    logic                      checksum_on   = 1'b0;
    logic                      frame_is_open = 1'b0;
    logic [sfe_pkg::ByteW-1:0] packet_xor    = '0;

    t_packet_word packet_words_todo[$];  // words still to be offered
    t_line_word   line_words_due[$];     // line words the block owes us

    int  fail_count  = 0;
    bit  hold_wanted = 1'b0;             // raised once by the stimulus to ask for the hold-off

    // a data byte as it goes on the line, END and ESC turned into two-word escapes
    function automatic void queue_escaped(input logic [sfe_pkg::ByteW-1:0] b);
        if (b == sfe_pkg::SlipEnd) begin
            line_words_due.push_back({sfe_pkg::SlipEsc, 1'b0});
            line_words_due.push_back({sfe_pkg::SlipEscEnd, 1'b0});
        end else if (b == sfe_pkg::SlipEsc) begin
            line_words_due.push_back({sfe_pkg::SlipEsc, 1'b0});
            line_words_due.push_back({sfe_pkg::SlipEscEsc, 1'b0});
        end else begin
            line_words_due.push_back({b, 1'b0});
        end
    endfunction

    // all line words caused by one accepted packet word
    function automatic void predict_line_words(input logic [sfe_pkg::ByteW-1:0] b,
                                               input logic is_last);
        t_line_word tail;
        // leading END opens a fresh frame and clears the running xor
        if (!frame_is_open) begin
            line_words_due.push_back({sfe_pkg::SlipEnd, 1'b0});
            frame_is_open = 1'b1;
            packet_xor    = '0;
        end
        packet_xor = packet_xor ^ b;
        queue_escaped(b);
        // the option is looked at only here, when the packet closes
        if (is_last) begin
            if (checksum_on)
                queue_escaped(packet_xor);
            line_words_due.push_back({sfe_pkg::SlipEnd, 1'b0});
            frame_is_open = 1'b0;
            packet_xor    = '0;
        end
        // the newest entry is always one of ours, so it closes the run
        tail             = line_words_due.pop_back();
        tail.last_of_run = 1'b1;
        line_words_due.push_back(tail);
    endfunction

    // ---------------------------------------------------------------
    // driver: bursts of random length with random gaps in between
    // ---------------------------------------------------------------
    int burst_left = 4;
    int gap_left   = 0;

    initial begin
        in_ch.valid     = 1'b0;
        in_ch.data_byte = '0;
        in_ch.last_byte = 1'b0;
        out_ch.ready    = 1'b0;
    end

    always @(posedge i_clk) begin
        t_packet_word w;
        logic         offer;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            // a word is taken at this edge: work out what it owes us
            if (in_ch.valid && in_ch.ready)
                predict_line_words(in_ch.data_byte, in_ch.last_byte);
            // the bus is free once nothing is held up waiting for ready
            if (!in_ch.valid || in_ch.ready) begin
                offer = 1'b0;
                if (gap_left != 0) begin
                    gap_left--;
                end else if (packet_words_todo.size() != 0) begin
                    w = packet_words_todo.pop_front();
                    in_ch.data_byte <= w.data;
                    in_ch.last_byte <= w.is_last;
                    offer = 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 16);
                        // a third of the bursts run straight on with no gap
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                in_ch.valid <= offer;
            end
        end
    end

    // ---------------------------------------------------------------
    // monitor: checks every line word and drives the receiver stalls
    // ---------------------------------------------------------------
    t_rx_mode rx_mode   = ReadyAlways;
    int       seg_left  = 0;
    int       rx_tick   = 0;
    int       hold_left = 0;
    bit       held_once = 1'b0;

    always @(posedge i_clk) begin
        t_line_word due;
        logic       next_ready;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (line_words_due.size() == 0) begin
                    $error("line word %02h arrived with nothing outstanding",
                           out_ch.line_byte);
                    fail_count++;
                end else begin
                    due = line_words_due.pop_front();
                    if (out_ch.line_byte !== due.line_byte) begin
                        $error("line_byte mismatch: expected %02h, got %02h",
                               due.line_byte, out_ch.line_byte);
                        fail_count++;
                    end
                    if (out_ch.last_of_run !== due.last_of_run) begin
                        $error("last_of_run mismatch: expected %0b, got %0b",
                               due.last_of_run, out_ch.last_of_run);
                        fail_count++;
                    end
                end
            end

            // one long hold-off while the sender keeps pushing, then the usual pattern
            if (hold_left != 0) begin
                hold_left--;
                next_ready = 1'b0;
            end else if (hold_wanted && !held_once) begin
                held_once  = 1'b1;
                hold_left  = HoldCycles - 1;
                next_ready = 1'b0;
            end else begin
                if (seg_left == 0) begin
                    rx_mode  = t_rx_mode'($urandom_range(0, 2));
                    seg_left = $urandom_range(8, 40);
                end
                seg_left--;
                rx_tick++;
                case (rx_mode)
                    ReadyAlways:   next_ready = 1'b1;
                    ReadyCoinFlip: next_ready = 1'($urandom_range(0, 1));
                    default:       next_ready = (rx_tick % 4 == 0);
                endcase
            end
            out_ch.ready <= next_ready;
        end
    end

    // ---------------------------------------------------------------
    // watchdog: too long with no word moving on either side
    // ---------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QuietLimit) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------
    task automatic queue_word(input logic [sfe_pkg::ByteW-1:0] data, input logic is_last);
        packet_words_todo.push_back({data, is_last});
    endtask

    // option register write; our copy changes as the write is driven, before the register
    task automatic write_checksum_option(input logic on);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= on;
        checksum_on  = on;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // wait until everything is offered, taken and answered, then the given spare cycles
    task automatic wait_for_drain(input int spare);
        do
            @(negedge i_clk);
        while (packet_words_todo.size() != 0 || in_ch.valid || line_words_due.size() != 0);
        repeat (spare) @(posedge i_clk);
    endtask

    // data bytes leaning towards the slip codes and the extremes
    function automatic logic [sfe_pkg::ByteW-1:0] pick_byte();
        case ($urandom_range(0, 9))
            0:       return sfe_pkg::SlipEnd;
            1:       return sfe_pkg::SlipEsc;
            2:       return sfe_pkg::SlipEscEnd;
            3:       return sfe_pkg::SlipEscEsc;
            4:       return 8'h00;
            5:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // whole packets of random length; the last one may be cut short and left open
    task automatic queue_random_packets(input int n_words);
        int count;
        int len;
        count = 0;
        while (count < n_words) begin
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
            for (int i = 0; i < len && count < n_words; i++) begin
                queue_word(pick_byte(), i == len - 1);
                count++;
            end
        end
    endtask

    initial begin
        repeat (ResetCycles) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // plain framing: single-byte packet, both extremes, every slip code,
        // then a frame left open across the option write
        write_checksum_option(1'b0);
        @(negedge i_clk);
        queue_word(8'h00, 1'b1);
        queue_word(8'hFF, 1'b0);
        queue_word(sfe_pkg::SlipEnd, 1'b0);
        queue_word(sfe_pkg::SlipEsc, 1'b0);
        queue_word(sfe_pkg::SlipEscEnd, 1'b0);
        queue_word(sfe_pkg::SlipEscEsc, 1'b0);
        queue_word(8'hAA, 1'b1);
        queue_word(8'h12, 1'b0);
        wait_for_drain(SettleGap);

        // option switched on in mid frame: the closing byte must pick it up
        write_checksum_option(1'b1);
        @(negedge i_clk);
        queue_word(8'h34, 1'b1);
        // escaped last byte with an escaped checksum, the longest run
        queue_word(sfe_pkg::SlipEnd, 1'b1);
        queue_word(sfe_pkg::SlipEsc, 1'b1);
        // checksum that happens to equal ESC, then END
        queue_word(8'h01, 1'b0);
        queue_word(8'hDA, 1'b1);
        queue_word(8'hFF, 1'b0);
        queue_word(8'h3F, 1'b1);
        // checksum of zero, and a plain single byte
        queue_word(8'h5A, 1'b0);
        queue_word(8'h5A, 1'b1);
        queue_word(8'hFF, 1'b1);
        wait_for_drain(SettleGap);

        // random phases, the option flipping between them
        for (int p = 0; p < 6; p++) begin
            write_checksum_option(p[0]);
            @(negedge i_clk);
            queue_random_packets(14);
            if (p == 2)
                hold_wanted = 1'b1;
            wait_for_drain(SettleGap);
        end

        wait_for_drain(TailCycles);
        if (fail_count == 0 && line_words_due.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* slip_frame_encoder.f */
design/sfe_pkg.sv
design/sfe_if.sv
design/sfe_expand.sv
design/sfe_emit.sv
design/slip_frame_encoder.sv
dv/slip_frame_encoder_tb.sv
